FILE: rtl/core/qsst_pkg.sv
// Package for the stream state table: field widths, slot count, command and
// part-state codes, and the packed payload and queue entry types.
// No dependencies; every other file refers to it by scoped names.
package qsst_pkg;

    // Table size and field widths
    localparam int NUM_SLOTS    = 64;
    localparam int SLOT_IDX_W   = $clog2(NUM_SLOTS);
    localparam int SLOT_FIELD_W = 6;
    localparam int CODE_W       = 62;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

    // Commands
    typedef enum logic [3:0] {
        CMD_ALLOC          = 4'd0,
        CMD_RELEASE        = 4'd1,
        CMD_ENSURE_SEND    = 4'd2,
        CMD_ALL_SENT       = 4'd3,
        CMD_ACKED          = 4'd4,
        CMD_RESET_SEND     = 4'd5,
        CMD_RESET_ACKED    = 4'd6,
        CMD_SIZE_KNOWN     = 4'd7,
        CMD_ALL_RECEIVED   = 4'd8,
        CMD_ALL_READ       = 4'd9,
        CMD_RESET_RECV     = 4'd10,
        CMD_APP_READ_RESET = 4'd11,
        CMD_STOP_REQ       = 4'd12,
        CMD_QUERY          = 4'd13
    } t_qsst_cmd;

    // Send part states
    typedef enum logic [2:0] {
        SP_NONE        = 3'd0,
        SP_READY       = 3'd1,
        SP_SEND        = 3'd2,
        SP_DATA_SENT   = 3'd3,
        SP_DATA_RECVD  = 3'd4,
        SP_RESET_SENT  = 3'd5,
        SP_RESET_RECVD = 3'd6
    } t_qsst_sp;

    // Receive part states
    typedef enum logic [2:0] {
        RP_NONE        = 3'd0,
        RP_RECV        = 3'd1,
        RP_SIZE_KNOWN  = 3'd2,
        RP_DATA_RECVD  = 3'd3,
        RP_DATA_READ   = 3'd4,
        RP_RESET_RECVD = 3'd5,
        RP_RESET_READ  = 3'd6
    } t_qsst_rp;

    // Back end sequencer states
    typedef enum logic {
        BS_FETCH = 1'b0,
        BS_EXEC  = 1'b1
    } t_qsst_bst;

    // Input word
    typedef struct packed {
        logic [3:0]              command;
        logic [SLOT_FIELD_W-1:0] slot;
        logic [1:0]              stream_type;
        logic [CODE_W-1:0]       error_code;
        logic                    final_size_known;
    } t_qsst_in;

    // Result word
    typedef struct packed {
        logic              ok;
        logic              slot_used;
        logic [2:0]        send_part_state;
        logic [2:0]        recv_part_state;
        logic              want_reset_frame;
        logic              want_stop_frame;
        logic              stop_requested;
        logic [CODE_W-1:0] local_reset_code;
        logic [CODE_W-1:0] peer_reset_code;
        logic [CODE_W-1:0] stop_code;
    } t_qsst_out;

    // Classified command as queued between front and back
    typedef struct packed {
        t_qsst_cmd             cmd;
        logic                  in_range;
        logic [SLOT_IDX_W-1:0] idx;
        logic [1:0]            stream_type;
        logic [CODE_W-1:0]     code;
        logic                  fsk;
    } t_qsst_op;

    // Per-slot control entry
    typedef struct packed {
        t_qsst_sp sp;
        t_qsst_rp rp;
        logic     want_reset;
        logic     want_stop;
        logic     stop_req;
    } t_qsst_ent;

    // Queue status toward the front and back
    typedef struct packed {
        logic full;
        logic not_empty;
    } t_qsst_qstat;

endpackage

FILE: rtl/core/qsst_front.sv
// Front end of the stream state table: takes command words and classifies
// them (command code, slot range check, table index) for the queue.
// Depends on qsst_pkg.
module qsst_front (
    input  logic               start,
    input  qsst_pkg::t_qsst_in i_cmd,
    input  qsst_pkg::t_qsst_qstat i_qstat,
    output logic               busy,
    output logic               o_push,
    output qsst_pkg::t_qsst_op o_op
);

    // Hold off new words while the queue is full
    assign busy   = i_qstat.full;
    assign o_push = start && !i_qstat.full;

    // Classify the word
    always_comb begin
        o_op.cmd         = qsst_pkg::t_qsst_cmd'(i_cmd.command);
        o_op.in_range    = 32'(i_cmd.slot) < qsst_pkg::NUM_SLOTS;
        o_op.idx         = qsst_pkg::SLOT_IDX_W'(i_cmd.slot);
        o_op.stream_type = i_cmd.stream_type;
        o_op.code        = i_cmd.error_code;
        o_op.fsk         = i_cmd.final_size_known;
    end

endmodule

FILE: rtl/core/qsst_queue.sv
// Short queue of classified commands between the front and back ends.
// Depends on qsst_pkg.
module qsst_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  qsst_pkg::t_qsst_op    i_op,
    input  logic                  i_pop,
    output qsst_pkg::t_qsst_op    o_op,
    output qsst_pkg::t_qsst_qstat o_stat
);

    qsst_pkg::t_qsst_op                  r_q [qsst_pkg::QUEUE_DEPTH];
    logic [qsst_pkg::QUEUE_PTR_W-1:0]    r_wp, n_wp;
    logic [qsst_pkg::QUEUE_PTR_W-1:0]    r_rp, n_rp;
    logic [qsst_pkg::QUEUE_CNT_W-1:0]    r_cnt, n_cnt;

    // Advance pointers and count
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (32'(r_wp) == qsst_pkg::QUEUE_DEPTH - 1) ?
                   '0 : r_wp + qsst_pkg::QUEUE_PTR_W'(1);
        end
        if (i_pop) begin
            n_rp = (32'(r_rp) == qsst_pkg::QUEUE_DEPTH - 1) ?
                   '0 : r_rp + qsst_pkg::QUEUE_PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + qsst_pkg::QUEUE_CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - qsst_pkg::QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Store pushed words
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_op;
        end
    end

    assign o_op             = r_q[r_rp];
    assign o_stat.full      = 32'(r_cnt) == qsst_pkg::QUEUE_DEPTH;
    assign o_stat.not_empty = r_cnt != '0;

endmodule

FILE: rtl/core/qsst_back.sv
// Back end of the stream state table: slot memories, the read-modify-write
// sequencer (fetch, then apply; one command at a time) and the result register.
// Depends on qsst_pkg.
module qsst_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_server_role,
    input  qsst_pkg::t_qsst_op    i_op,
    input  qsst_pkg::t_qsst_qstat i_qstat,
    output logic                  o_pop,
    output logic                  o_done,
    output qsst_pkg::t_qsst_out   o_result
);

    // Slot storage
    logic [qsst_pkg::NUM_SLOTS-1:0]  r_valid;
    qsst_pkg::t_qsst_ent             r_ent_mem  [qsst_pkg::NUM_SLOTS];
    logic [qsst_pkg::CODE_W-1:0]     r_lrc_mem  [qsst_pkg::NUM_SLOTS];
    logic [qsst_pkg::CODE_W-1:0]     r_prc_mem  [qsst_pkg::NUM_SLOTS];
    logic [qsst_pkg::CODE_W-1:0]     r_stc_mem  [qsst_pkg::NUM_SLOTS];

    // Fetched slot and command
    qsst_pkg::t_qsst_op          r_op;
    logic                        r_vld_rd;
    qsst_pkg::t_qsst_ent         r_ent_rd;
    logic [qsst_pkg::CODE_W-1:0] r_lrc_rd;
    logic [qsst_pkg::CODE_W-1:0] r_prc_rd;
    logic [qsst_pkg::CODE_W-1:0] r_stc_rd;

    qsst_pkg::t_qsst_bst r_state, n_state;
    logic                r_done;
    qsst_pkg::t_qsst_out r_res;

    // Execute-stage signals
    logic                        exec;
    logic                        vld;
    qsst_pkg::t_qsst_ent         ent;
    qsst_pkg::t_qsst_ent         n_ent;
    logic                        n_vld;
    logic                        ok;
    logic                        local_strm;
    logic                        bidi;
    logic                        we_lrc, we_prc, we_stc;
    logic [qsst_pkg::CODE_W-1:0] wr_code;
    logic [qsst_pkg::CODE_W-1:0] n_lrc, n_prc, n_stc;
    qsst_pkg::t_qsst_out         n_res;

    // Sequencer: fetch a slot, then apply and write back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qsst_pkg::BS_FETCH;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        exec    = 1'b0;
        unique case (r_state)
            qsst_pkg::BS_FETCH: begin
                if (i_qstat.not_empty) begin
                    o_pop   = 1'b1;
                    n_state = qsst_pkg::BS_EXEC;
                end
            end
            qsst_pkg::BS_EXEC: begin
                exec    = 1'b1;
                n_state = qsst_pkg::BS_FETCH;
            end
            default: begin
                n_state = qsst_pkg::BS_FETCH;
            end
        endcase
    end

    // Read the slot memories on pop
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_op     <= i_op;
            r_vld_rd <= r_valid[i_op.idx];
            r_ent_rd <= r_ent_mem[i_op.idx];
            r_lrc_rd <= r_lrc_mem[i_op.idx];
            r_prc_rd <= r_prc_mem[i_op.idx];
            r_stc_rd <= r_stc_mem[i_op.idx];
        end
    end

    // Apply the command to the fetched slot
    always_comb begin
        vld        = r_op.in_range && r_vld_rd;
        ent        = vld ? r_ent_rd : '0;
        n_ent      = ent;
        n_vld      = vld;
        ok         = 1'b0;
        we_lrc     = 1'b0;
        we_prc     = 1'b0;
        we_stc     = 1'b0;
        wr_code    = r_op.code;
        local_strm = r_op.stream_type[0] == i_server_role;
        bidi       = !r_op.stream_type[1];
        if (r_op.in_range) begin
            if (r_op.cmd == qsst_pkg::CMD_ALLOC) begin
                if (!vld) begin
                    ok      = 1'b1;
                    n_vld   = 1'b1;
                    n_ent   = '0;
                    n_ent.sp = (local_strm || bidi) ? qsst_pkg::SP_READY :
                               qsst_pkg::SP_NONE;
                    n_ent.rp = (!local_strm || bidi) ? qsst_pkg::RP_RECV :
                               qsst_pkg::RP_NONE;
                    wr_code = '0;
                    we_lrc  = 1'b1;
                    we_prc  = 1'b1;
                    we_stc  = 1'b1;
                end
            end else if (vld) begin
                unique case (r_op.cmd)
                    qsst_pkg::CMD_RELEASE: begin
                        ok    = 1'b1;
                        n_vld = 1'b0;
                        n_ent = '0;
                    end
                    qsst_pkg::CMD_ENSURE_SEND: begin
                        ok = ent.sp != qsst_pkg::SP_NONE &&
                             ent.sp <= qsst_pkg::SP_RESET_RECVD;
                        if (ent.sp == qsst_pkg::SP_READY) begin
                            n_ent.sp = qsst_pkg::SP_SEND;
                        end
                    end
                    qsst_pkg::CMD_ALL_SENT: begin
                        if (ent.sp == qsst_pkg::SP_SEND && r_op.fsk) begin
                            ok       = 1'b1;
                            n_ent.sp = qsst_pkg::SP_DATA_SENT;
                        end
                    end
                    qsst_pkg::CMD_ACKED: begin
                        if (ent.sp == qsst_pkg::SP_DATA_SENT) begin
                            ok       = 1'b1;
                            n_ent.sp = qsst_pkg::SP_DATA_RECVD;
                        end
                    end
                    qsst_pkg::CMD_RESET_SEND: begin
                        if (ent.sp == qsst_pkg::SP_READY ||
                            ent.sp == qsst_pkg::SP_SEND ||
                            ent.sp == qsst_pkg::SP_DATA_SENT) begin
                            ok               = 1'b1;
                            n_ent.sp         = qsst_pkg::SP_RESET_SENT;
                            n_ent.want_reset = 1'b1;
                            we_lrc           = 1'b1;
                        end else begin
                            ok = ent.sp == qsst_pkg::SP_RESET_SENT ||
                                 ent.sp == qsst_pkg::SP_RESET_RECVD;
                        end
                    end
                    qsst_pkg::CMD_RESET_ACKED: begin
                        ok = ent.sp == qsst_pkg::SP_RESET_SENT ||
                             ent.sp == qsst_pkg::SP_RESET_RECVD;
                        if (ent.sp == qsst_pkg::SP_RESET_SENT) begin
                            n_ent.sp = qsst_pkg::SP_RESET_RECVD;
                        end
                    end
                    qsst_pkg::CMD_SIZE_KNOWN: begin
                        if (ent.rp == qsst_pkg::RP_RECV) begin
                            ok       = 1'b1;
                            n_ent.rp = qsst_pkg::RP_SIZE_KNOWN;
                        end
                    end
                    qsst_pkg::CMD_ALL_RECEIVED: begin
                        if (ent.rp == qsst_pkg::RP_SIZE_KNOWN) begin
                            ok       = 1'b1;
                            n_ent.rp = qsst_pkg::RP_DATA_RECVD;
                        end
                    end
                    qsst_pkg::CMD_ALL_READ: begin
                        if (ent.rp == qsst_pkg::RP_DATA_RECVD) begin
                            ok       = 1'b1;
                            n_ent.rp = qsst_pkg::RP_DATA_READ;
                        end
                    end
                    qsst_pkg::CMD_RESET_RECV: begin
                        if (ent.rp == qsst_pkg::RP_RECV ||
                            ent.rp == qsst_pkg::RP_SIZE_KNOWN ||
                            ent.rp == qsst_pkg::RP_DATA_RECVD) begin
                            ok              = 1'b1;
                            n_ent.rp        = qsst_pkg::RP_RESET_RECVD;
                            n_ent.want_stop = 1'b0;
                            we_prc          = 1'b1;
                        end else begin
                            ok = ent.rp == qsst_pkg::RP_DATA_READ ||
                                 ent.rp == qsst_pkg::RP_RESET_RECVD ||
                                 ent.rp == qsst_pkg::RP_RESET_READ;
                        end
                    end
                    qsst_pkg::CMD_APP_READ_RESET: begin
                        if (ent.rp == qsst_pkg::RP_RESET_RECVD) begin
                            ok       = 1'b1;
                            n_ent.rp = qsst_pkg::RP_RESET_READ;
                        end
                    end
                    qsst_pkg::CMD_STOP_REQ: begin
                        if (!ent.stop_req) begin
                            ok              = 1'b1;
                            n_ent.stop_req  = 1'b1;
                            n_ent.want_stop = 1'b1;
                            we_stc          = 1'b1;
                        end
                    end
                    qsst_pkg::CMD_QUERY: begin
                        ok = 1'b1;
                    end
                    default: begin
                        ok = 1'b0;
                    end
                endcase
            end
        end

        // Code values after the command
        n_lrc = we_lrc ? wr_code : r_lrc_rd;
        n_prc = we_prc ? wr_code : r_prc_rd;
        n_stc = we_stc ? wr_code : r_stc_rd;

        // Build the result; an unused slot reports zeros
        n_res    = '0;
        n_res.ok = ok;
        if (n_vld) begin
            n_res.slot_used        = 1'b1;
            n_res.send_part_state  = n_ent.sp;
            n_res.recv_part_state  = n_ent.rp;
            n_res.want_reset_frame = n_ent.want_reset;
            n_res.want_stop_frame  = n_ent.want_stop;
            n_res.stop_requested   = n_ent.stop_req;
            n_res.local_reset_code = n_lrc;
            n_res.peer_reset_code  = n_prc;
            n_res.stop_code        = n_stc;
        end
    end

    // Write back slot state
    always_ff @(posedge i_clk) begin
        if (exec && r_op.in_range) begin
            r_ent_mem[r_op.idx] <= n_ent;
            if (we_lrc) begin
                r_lrc_mem[r_op.idx] <= wr_code;
            end
            if (we_prc) begin
                r_prc_mem[r_op.idx] <= wr_code;
            end
            if (we_stc) begin
                r_stc_mem[r_op.idx] <= wr_code;
            end
        end
    end

    // Occupancy bits, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (exec && r_op.in_range) begin
            r_valid[r_op.idx] <= n_vld;
        end
    end

    // Result register and strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= exec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_res <= n_res;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

FILE: rtl/core/quic_stream_state_table.sv
// Stream state table, top level: configuration register, front end,
// command queue and back end. Depends on qsst_pkg and the qsst_* modules.
//
// A command word is taken when start is high and busy is low. The back end
// handles one command at a time: it reads the slot's memories, then applies
// the command, writes the slot back and loads the result register. A two-deep
// queue sits in front of the back end; busy rises only when that queue is
// full. With the table idle, a taken command passes the queue, the fetch
// registers and the result register before o_done rises, and the result is
// shown for exactly one cycle with o_done high; the receiver must take it at
// the next rising edge. Results come out in command order. The server-role
// register is written through the cfg channel, which is always ready, and
// must only change while no command is in flight.
module quic_stream_state_table (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  qsst_pkg::t_qsst_in  i_cmd,
    output logic                o_done,
    output qsst_pkg::t_qsst_out o_result,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_data
);

    logic                  r_server_role;
    logic                  push;
    logic                  pop;
    qsst_pkg::t_qsst_op    front_op;
    qsst_pkg::t_qsst_op    head_op;
    qsst_pkg::t_qsst_qstat qstat;

    // Configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_server_role <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_server_role <= i_cfg_data;
        end
    end

    qsst_front u_front (
        .start   (start),
        .i_cmd   (i_cmd),
        .i_qstat (qstat),
        .busy    (busy),
        .o_push  (push),
        .o_op    (front_op)
    );

    qsst_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (front_op),
        .i_pop   (pop),
        .o_op    (head_op),
        .o_stat  (qstat)
    );

    qsst_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_server_role (r_server_role),
        .i_op          (head_op),
        .i_qstat       (qstat),
        .o_pop         (pop),
        .o_done        (o_done),
        .o_result      (o_result)
    );

    // No result strobes in back-to-back cycles
    a_done_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobes in back-to-back cycles");

    // An unused slot reports all-zero contents
    a_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.slot_used) |->
            (o_result.send_part_state == 3'd0 &&
             o_result.recv_part_state == 3'd0 &&
             !o_result.want_reset_frame && !o_result.want_stop_frame &&
             !o_result.stop_requested &&
             o_result.local_reset_code == '0 &&
             o_result.peer_reset_code == '0 &&
             o_result.stop_code == '0))
        else $error("unused slot reported nonzero contents");

    // Out of reset the block is free and shows no result
    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (!busy && !o_done))
        else $error("busy or result strobe right after reset");

endmodule

FILE: sim/qsst_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the stream state table: tracks its own copy of every slot,
// predicts each result word and compares it field by field with the block.
// Depends on qsst_pkg for the payload types and the command and state codes.
module qsst_result_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_busy,
    input  qsst_pkg::t_qsst_in  i_cmd,
    input  logic                i_done,
    input  qsst_pkg::t_qsst_out i_result,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic                i_cfg_data,
    output int                  o_mismatches,
    output int                  o_pending,
    output int                  o_compared
);

    typedef struct {
        qsst_pkg::t_qsst_in  word;
        qsst_pkg::t_qsst_out result;
    } t_awaited;

    // Shadow copy of the table and the server-role register
    logic                        server_mode;
    logic                        slot_live   [qsst_pkg::NUM_SLOTS];
    qsst_pkg::t_qsst_sp          send_st     [qsst_pkg::NUM_SLOTS];
    qsst_pkg::t_qsst_rp          recv_st     [qsst_pkg::NUM_SLOTS];
    logic                        stop_req    [qsst_pkg::NUM_SLOTS];
    logic                        want_stop   [qsst_pkg::NUM_SLOTS];
    logic                        want_reset  [qsst_pkg::NUM_SLOTS];
    logic [qsst_pkg::CODE_W-1:0] local_code  [qsst_pkg::NUM_SLOTS];
    logic [qsst_pkg::CODE_W-1:0] peer_code   [qsst_pkg::NUM_SLOTS];
    logic [qsst_pkg::CODE_W-1:0] stop_code_q [qsst_pkg::NUM_SLOTS];

    t_awaited awaited_results[$];

    function automatic void wipe_slot(int s);
        slot_live[s]   = 1'b0;
        send_st[s]     = qsst_pkg::SP_NONE;
        recv_st[s]     = qsst_pkg::RP_NONE;
        stop_req[s]    = 1'b0;
        want_stop[s]   = 1'b0;
        want_reset[s]  = 1'b0;
        local_code[s]  = '0;
        peer_code[s]   = '0;
        stop_code_q[s] = '0;
    endfunction

    // Apply one command to an allocated slot; return the ok bit
    function automatic logic step_live_slot(int s, qsst_pkg::t_qsst_in w);
        case (w.command)
            qsst_pkg::CMD_RELEASE: begin
                wipe_slot(s);
                return 1'b1;
            end
            qsst_pkg::CMD_ENSURE_SEND: begin
                if (send_st[s] == qsst_pkg::SP_NONE)
                    return 1'b0;
                if (send_st[s] == qsst_pkg::SP_READY)
                    send_st[s] = qsst_pkg::SP_SEND;
                return 1'b1;
            end
            qsst_pkg::CMD_ALL_SENT: begin
                if (send_st[s] != qsst_pkg::SP_SEND || !w.final_size_known)
                    return 1'b0;
                send_st[s] = qsst_pkg::SP_DATA_SENT;
                return 1'b1;
            end
            qsst_pkg::CMD_ACKED: begin
                if (send_st[s] != qsst_pkg::SP_DATA_SENT)
                    return 1'b0;
                send_st[s] = qsst_pkg::SP_DATA_RECVD;
                return 1'b1;
            end
            qsst_pkg::CMD_RESET_SEND: begin
                if (send_st[s] inside {qsst_pkg::SP_READY, qsst_pkg::SP_SEND,
                                       qsst_pkg::SP_DATA_SENT}) begin
                    local_code[s] = w.error_code;
                    send_st[s]    = qsst_pkg::SP_RESET_SENT;
                    want_reset[s] = 1'b1;
                    return 1'b1;
                end
                return send_st[s] inside {qsst_pkg::SP_RESET_SENT,
                                          qsst_pkg::SP_RESET_RECVD};
            end
            qsst_pkg::CMD_RESET_ACKED: begin
                if (send_st[s] == qsst_pkg::SP_RESET_SENT) begin
                    send_st[s] = qsst_pkg::SP_RESET_RECVD;
                    return 1'b1;
                end
                return send_st[s] == qsst_pkg::SP_RESET_RECVD;
            end
            qsst_pkg::CMD_SIZE_KNOWN: begin
                if (recv_st[s] != qsst_pkg::RP_RECV)
                    return 1'b0;
                recv_st[s] = qsst_pkg::RP_SIZE_KNOWN;
                return 1'b1;
            end
            qsst_pkg::CMD_ALL_RECEIVED: begin
                if (recv_st[s] != qsst_pkg::RP_SIZE_KNOWN)
                    return 1'b0;
                recv_st[s] = qsst_pkg::RP_DATA_RECVD;
                return 1'b1;
            end
            qsst_pkg::CMD_ALL_READ: begin
                if (recv_st[s] != qsst_pkg::RP_DATA_RECVD)
                    return 1'b0;
                recv_st[s] = qsst_pkg::RP_DATA_READ;
                return 1'b1;
            end
            qsst_pkg::CMD_RESET_RECV: begin
                // a peer reset drops any pending stop frame request
                if (recv_st[s] inside {qsst_pkg::RP_RECV, qsst_pkg::RP_SIZE_KNOWN,
                                       qsst_pkg::RP_DATA_RECVD}) begin
                    recv_st[s]   = qsst_pkg::RP_RESET_RECVD;
                    peer_code[s] = w.error_code;
                    want_stop[s] = 1'b0;
                    return 1'b1;
                end
                return recv_st[s] inside {qsst_pkg::RP_DATA_READ,
                                          qsst_pkg::RP_RESET_RECVD,
                                          qsst_pkg::RP_RESET_READ};
            end
            qsst_pkg::CMD_APP_READ_RESET: begin
                if (recv_st[s] != qsst_pkg::RP_RESET_RECVD)
                    return 1'b0;
                recv_st[s] = qsst_pkg::RP_RESET_READ;
                return 1'b1;
            end
            qsst_pkg::CMD_STOP_REQ: begin
                if (stop_req[s])
                    return 1'b0;
                stop_req[s]    = 1'b1;
                want_stop[s]   = 1'b1;
                stop_code_q[s] = w.error_code;
                return 1'b1;
            end
            qsst_pkg::CMD_QUERY:
                return 1'b1;
            default:
                return 1'b0;
        endcase
    endfunction

    // Update the shadow table for one command word and build its result word
    function automatic qsst_pkg::t_qsst_out execute_command(qsst_pkg::t_qsst_in w);
        qsst_pkg::t_qsst_out r;
        int                  s;
        logic                ok;
        logic                local_side;
        logic                bidi;
        s  = int'(w.slot);
        ok = 1'b0;
        r  = '0;
        if (s < qsst_pkg::NUM_SLOTS) begin
            if (w.command == qsst_pkg::CMD_ALLOC) begin
                if (!slot_live[s]) begin
                    local_side = (w.stream_type[0] == server_mode);
                    bidi       = !w.stream_type[1];
                    wipe_slot(s);
                    slot_live[s] = 1'b1;
                    send_st[s]   = (local_side || bidi) ? qsst_pkg::SP_READY :
                                   qsst_pkg::SP_NONE;
                    recv_st[s]   = (!local_side || bidi) ? qsst_pkg::RP_RECV :
                                   qsst_pkg::RP_NONE;
                    ok = 1'b1;
                end
            end else if (slot_live[s]) begin
                ok = step_live_slot(s, w);
            end
            // an empty slot reports all zeros apart from ok
            if (slot_live[s]) begin
                r.slot_used        = 1'b1;
                r.send_part_state  = send_st[s];
                r.recv_part_state  = recv_st[s];
                r.want_reset_frame = want_reset[s];
                r.want_stop_frame  = want_stop[s];
                r.stop_requested   = stop_req[s];
                r.local_reset_code = local_code[s];
                r.peer_reset_code  = peer_code[s];
                r.stop_code        = stop_code_q[s];
            end
        end
        r.ok = ok;
        return r;
    endfunction

    task automatic check_field(input string name,
                               input logic [qsst_pkg::CODE_W-1:0] exp_v,
                               input logic [qsst_pkg::CODE_W-1:0] act_v,
                               input qsst_pkg::t_qsst_in w);
        if (act_v !== exp_v) begin
            $error("slot %0d cmd %0d: %s expected 0x%0h, got 0x%0h",
                   w.slot, w.command, name, exp_v, act_v);
            o_mismatches++;
        end
    endtask

    // Watch all three channels at the rising edge; check results before taking new words
    always @(posedge i_clk) begin : watch
        t_awaited head;
        if (!i_rst_n) begin
            server_mode = 1'b0;
            for (int s = 0; s < qsst_pkg::NUM_SLOTS; s++)
                wipe_slot(s);
            awaited_results.delete();
            o_mismatches = 0;
            o_compared   = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                server_mode = i_cfg_data;
            if (i_done === 1'b1) begin
                if (awaited_results.size() == 0) begin
                    $error("result word arrived with no command outstanding");
                    o_mismatches++;
                end else begin
                    head = awaited_results.pop_front();
                    o_compared++;
                    check_field("ok", head.result.ok, i_result.ok, head.word);
                    check_field("slot_used", head.result.slot_used,
                                i_result.slot_used, head.word);
                    check_field("send_part_state", head.result.send_part_state,
                                i_result.send_part_state, head.word);
                    check_field("recv_part_state", head.result.recv_part_state,
                                i_result.recv_part_state, head.word);
                    check_field("want_reset_frame", head.result.want_reset_frame,
                                i_result.want_reset_frame, head.word);
                    check_field("want_stop_frame", head.result.want_stop_frame,
                                i_result.want_stop_frame, head.word);
                    check_field("stop_requested", head.result.stop_requested,
                                i_result.stop_requested, head.word);
                    check_field("local_reset_code", head.result.local_reset_code,
                                i_result.local_reset_code, head.word);
                    check_field("peer_reset_code", head.result.peer_reset_code,
                                i_result.peer_reset_code, head.word);
                    check_field("stop_code", head.result.stop_code,
                                i_result.stop_code, head.word);
                end
            end
            if (i_start && !i_busy) begin
                head.word   = i_cmd;
                head.result = execute_command(i_cmd);
                awaited_results.push_back(head);
            end
        end
        o_pending = awaited_results.size();
    end

endmodule

FILE: sim/tb_quic_stream_state_table.sv
`timescale 1ns / 1ps
// Testbench top for the stream state table: clock, reset, command and config
// stimulus, watchdog and verdict. Depends on qsst_pkg, the block and qsst_result_checker.
module tb_quic_stream_state_table;

    localparam int            PHASES          = 4;
    localparam int            WORDS_PER_PHASE = 230;
    localparam int            POOL_SIZE       = 6;
    localparam int            DRAIN_CYCLES    = 8;
    localparam int            WATCHDOG_LIMIT  = 5000;
    localparam logic [3:0]    CMD_UNKNOWN_LO  = 4'd14;
    localparam logic [3:0]    CMD_UNKNOWN_HI  = 4'd15;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    qsst_pkg::t_qsst_in  i_cmd;
    logic                o_done;
    qsst_pkg::t_qsst_out o_result;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic                i_cfg_data;

    int   mismatches;
    int   pending;
    int   compared;
    int   words_sent   = 0;
    int   quiet_cycles = 0;
    logic idle_enable  = 1'b1;
    int   slot_pool [POOL_SIZE];

    quic_stream_state_table uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    qsst_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_cmd        (i_cmd),
        .i_done       (o_done),
        .i_result     (o_result),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_compared   (compared)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // End the run when nothing moves on any channel for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done === 1'b1 || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL quic_stream_state_table");
            $finish;
        end
    end

    function automatic logic [qsst_pkg::CODE_W-1:0] rand_code();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return raw[qsst_pkg::CODE_W-1:0];
        endcase
    endfunction

    // Lean toward stream events so slots get deep into both parts
    function automatic logic [3:0] pick_command();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return qsst_pkg::CMD_ALLOC;
        if (r < 14)
            return qsst_pkg::CMD_RELEASE;
        if (r < 15)
            return CMD_UNKNOWN_LO;
        if (r < 16)
            return CMD_UNKNOWN_HI;
        if (r < 20)
            return qsst_pkg::CMD_QUERY;
        return 4'($urandom_range(qsst_pkg::CMD_ENSURE_SEND, qsst_pkg::CMD_STOP_REQ));
    endfunction

    // Present one command word at the falling edge and hold it until taken
    task automatic send_word(input logic [3:0] cmd,
                             input logic [qsst_pkg::SLOT_FIELD_W-1:0] slot,
                             input logic [1:0] stype,
                             input logic [qsst_pkg::CODE_W-1:0] code,
                             input logic fsk);
        qsst_pkg::t_qsst_in w;
        w.command          = cmd;
        w.slot             = slot;
        w.stream_type      = stype;
        w.error_code       = code;
        w.final_size_known = fsk;
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= w;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        words_sent++;
        @(negedge i_clk);
    endtask

    // Drop start and wait until every result word has come back
    task automatic settle_table();
        start <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_server_role(input logic value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [qsst_pkg::SLOT_FIELD_W-1:0] slot;
        start       = 1'b0;
        i_cmd       = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = 1'b0;
        i_rst_n     = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty slots, a full walk of both parts, idempotent events
        send_word(qsst_pkg::CMD_QUERY,          6'd0,  2'd3, '1, 1'b1);
        send_word(qsst_pkg::CMD_RELEASE,        6'd63, 2'd0, '0, 1'b0);
        send_word(qsst_pkg::CMD_ALLOC,          6'd0,  2'd0, '1, 1'b1);
        send_word(qsst_pkg::CMD_ALLOC,          6'd0,  2'd3, '0, 1'b0);
        send_word(qsst_pkg::CMD_ENSURE_SEND,    6'd0,  2'd0, '0, 1'b0);
        send_word(qsst_pkg::CMD_ENSURE_SEND,    6'd0,  2'd0, '0, 1'b0);
        send_word(qsst_pkg::CMD_ALL_SENT,       6'd0,  2'd0, '0, 1'b0);
        send_word(qsst_pkg::CMD_ALL_SENT,       6'd0,  2'd0, '0, 1'b1);
        send_word(qsst_pkg::CMD_RESET_SEND,     6'd0,  2'd0, '1, 1'b0);
        send_word(qsst_pkg::CMD_RESET_SEND,     6'd0,  2'd0, '0, 1'b0);
        send_word(qsst_pkg::CMD_RESET_ACKED,    6'd0,  2'd0, '0, 1'b0);
        send_word(qsst_pkg::CMD_RESET_ACKED,    6'd0,  2'd0, '0, 1'b0);
        send_word(qsst_pkg::CMD_SIZE_KNOWN,     6'd0,  2'd0, '0, 1'b0);
        send_word(qsst_pkg::CMD_STOP_REQ,       6'd0,  2'd0, '1, 1'b0);
        send_word(qsst_pkg::CMD_RESET_RECV,     6'd0,  2'd0, rand_code(), 1'b0);
        send_word(qsst_pkg::CMD_STOP_REQ,       6'd0,  2'd0, '0, 1'b0);
        send_word(qsst_pkg::CMD_APP_READ_RESET, 6'd0,  2'd0, '0, 1'b0);
        send_word(CMD_UNKNOWN_HI,               6'd0,  2'd0, '1, 1'b1);
        send_word(qsst_pkg::CMD_ALLOC,          6'd63, 2'd3, '0, 1'b0);
        send_word(qsst_pkg::CMD_SIZE_KNOWN,     6'd63, 2'd0, '0, 1'b0);
        send_word(qsst_pkg::CMD_ALL_RECEIVED,   6'd63, 2'd0, '0, 1'b0);
        send_word(qsst_pkg::CMD_ALL_READ,       6'd63, 2'd0, '0, 1'b0);
        send_word(qsst_pkg::CMD_RESET_RECV,     6'd63, 2'd0, '1, 1'b0);
        send_word(qsst_pkg::CMD_ALLOC,          6'd62, 2'd2, '0, 1'b0);
        send_word(qsst_pkg::CMD_ENSURE_SEND,    6'd62, 2'd0, '0, 1'b0);
        send_word(qsst_pkg::CMD_ALL_SENT,       6'd62, 2'd0, '0, 1'b1);
        send_word(qsst_pkg::CMD_ACKED,          6'd62, 2'd0, '0, 1'b0);
        send_word(qsst_pkg::CMD_RELEASE,        6'd0,  2'd0, '0, 1'b0);

        // Random: alternate the server role, work a small slot pool hard, no idling at the end
        for (int p = 0; p < PHASES; p++) begin
            settle_table();
            write_server_role(p % 2 == 0);
            idle_enable = (p != PHASES - 1);
            for (int k = 0; k < POOL_SIZE; k++)
                slot_pool[k] = $urandom_range(0, qsst_pkg::NUM_SLOTS - 1);
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                if ($urandom_range(0, 9) == 0)
                    slot = qsst_pkg::SLOT_FIELD_W'($urandom_range(0, qsst_pkg::NUM_SLOTS - 1));
                else
                    slot = qsst_pkg::SLOT_FIELD_W'(slot_pool[$urandom_range(0, POOL_SIZE - 1)]);
                send_word(pick_command(), slot, 2'($urandom_range(0, 3)), rand_code(),
                          $urandom_range(0, 4) != 0);
            end
        end
        settle_table();

        $display("Covered %0d command words over directed walks and %0d server-role phases;",
                 words_sent, PHASES);
        $display("%0d result words compared, %0d mismatches.", compared, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("PASS quic_stream_state_table");
        else
            $display("FAIL quic_stream_state_table");
        $finish;
    end

endmodule

FILE: quic_stream_state_table.f
rtl/core/qsst_pkg.sv
rtl/core/qsst_front.sv
rtl/core/qsst_queue.sv
rtl/core/qsst_back.sv
rtl/core/quic_stream_state_table.sv
sim/qsst_result_checker.sv
sim/tb_quic_stream_state_table.sv
